// ===== hw/rtl/jrem_pkg.sv =====
// Shared types and constants for the joystick report event mapper.
// Depends on nothing; jrem_out_stage, jrem_engine and the top level import it.
package jrem_pkg;

    // Command codes of the input word.
    localparam logic CMD_REPORT    = 1'b0;
    localparam logic CMD_MAP_WRITE = 1'b1;

    // Word offsets inside one map slot.
    localparam int WORD_INCR  = 0;
    localparam int WORD_DOWN  = 1;
    localparam int WORD_UP    = 2;
    localparam int WORD_BAND0 = 3;

    // Number of physical axes a report carries.
    localparam int AXIS_LIMIT = 4;

    // Rotary recentering constants.
    localparam logic [7:0] ROT_CENTER   = 8'd127;
    localparam logic [7:0] ROT_NEG_BIAS = 8'd127;
    localparam logic [7:0] ROT_POS_BIAS = 8'd128;
    localparam logic [8:0] POS_TOP      = 9'd255;

    typedef enum logic [1:0] {
        KIND_PRESS   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_AXIS    = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [5:0] index;
        logic [3:0] value;
        logic       last;
    } t_event;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BTN,
        ST_FLAG,
        ST_DOWN,
        ST_UP,
        ST_INC,
        ST_BAND,
        ST_EMIT,
        ST_DONE
    } t_state;

    // Signed rotary reading moved onto the unsigned 0..255 scale.
    function automatic logic [7:0] recenter(input logic [7:0] raw);
        logic [7:0] res;
        if (raw == 8'd0) begin
            res = ROT_CENTER;
        end else if (raw[7]) begin
            res = raw + ROT_NEG_BIAS;
        end else begin
            res = raw + ROT_POS_BIAS;
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/jrem_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one read port,
// registered read data. No dependencies.
module jrem_ram #(
    parameter int DEPTH = 72,
    parameter int WIDTH = 8,
    parameter int AW    = 7
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/jrem_out_stage.sv =====
// One-entry output register of the event channel.
// Depends on jrem_pkg for the event type.
module jrem_out_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  jrem_pkg::t_event i_ev,
    output logic            o_ready,
    output logic            o_valid,
    output jrem_pkg::t_event o_ev,
    input  logic            i_stall
);
    import jrem_pkg::*;

    logic   r_valid;
    t_event r_ev;

    // A new word may load when the register is empty or is being taken.
    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push && o_ready) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && o_ready) begin
            r_ev <= i_ev;
        end
    end

    assign o_valid = r_valid;
    assign o_ev    = r_ev;

endmodule

// ===== hw/rtl/jrem_engine.sv =====
// Sequencer of the event mapper: clearing pass, button scan and axis
// translation over the map and position memories. Depends on jrem_pkg.
module jrem_engine #(
    parameter int NUM_PLANES       = 2,
    parameter int NUM_MODES        = 3,
    parameter int NUM_SUBMODES     = 3,
    parameter int NUM_AXES         = 4,
    parameter int NUM_BANDS        = 15,
    parameter int NUM_BUTTON_BYTES = 5,
    parameter int SLOT_W           = 7,
    parameter int MAP_AW           = 11
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_command,
    input  logic [39:0]       i_buttons,
    input  logic [7:0]        i_axis_x,
    input  logic [7:0]        i_axis_y,
    input  logic [7:0]        i_rotary_a,
    input  logic [7:0]        i_rotary_b,
    input  logic              i_shift_plane,
    input  logic [1:0]        i_mode_sel,
    input  logic [1:0]        i_submode_sel,
    input  logic [6:0]        i_map_slot,
    input  logic [4:0]        i_map_word,
    input  logic [7:0]        i_map_value,
    // map table memory
    output logic              o_map_we,
    output logic [MAP_AW-1:0] o_map_waddr,
    output logic [7:0]        o_map_wdata,
    output logic              o_map_re,
    output logic [MAP_AW-1:0] o_map_raddr,
    input  logic [7:0]        i_map_rdata,
    // remembered position memory
    output logic              o_pos_we,
    output logic [SLOT_W-1:0] o_pos_waddr,
    output logic [7:0]        o_pos_wdata,
    output logic              o_pos_re,
    output logic [SLOT_W-1:0] o_pos_raddr,
    input  logic [7:0]        i_pos_rdata,
    // event output
    output logic              o_push,
    output jrem_pkg::t_event  o_ev,
    input  logic              i_out_ready
);
    import jrem_pkg::*;

    localparam int WPS         = NUM_BANDS + 3;
    localparam int NUM_SLOTS   = NUM_PLANES * NUM_MODES * NUM_SUBMODES * NUM_AXES;
    localparam int MAP_DEPTH   = NUM_SLOTS * WPS;
    localparam int BUTTON_BITS = (NUM_BUTTON_BYTES * 8 < 40) ? NUM_BUTTON_BYTES * 8 : 40;
    localparam int BTN_IW      = $clog2(BUTTON_BITS);
    localparam int NAX         = (NUM_AXES < AXIS_LIMIT) ? NUM_AXES : AXIS_LIMIT;
    localparam int BAND_W      = $clog2(NUM_BANDS + 1);

    t_state               r_state, n_state;
    logic [MAP_AW-1:0]    r_clr, n_clr;
    logic [BUTTON_BITS-1:0] r_prev_btn, n_prev_btn;
    logic [BUTTON_BITS-1:0] r_diff, n_diff;
    logic [BUTTON_BITS-1:0] r_now, n_now;
    logic [7:0]           r_pos [AXIS_LIMIT];
    logic [7:0]           n_pos [AXIS_LIMIT];
    logic                 r_sel_ok, n_sel_ok;
    logic [SLOT_W-1:0]    r_slot, n_slot;
    logic [MAP_AW-1:0]    r_map_addr, n_map_addr;
    logic [1:0]           r_axis, n_axis;
    logic                 r_incr, n_incr;
    logic [7:0]           r_old, n_old;
    logic [7:0]           r_down, n_down;
    logic [7:0]           r_prev, n_prev;
    logic [BAND_W-1:0]    r_i, n_i;
    logic                 r_hit, n_hit;
    logic [3:0]           r_val, n_val;
    logic                 r_pend_valid, n_pend_valid;
    t_event               r_pend, n_pend;

    logic [BUTTON_BITS-1:0] btn_now;
    logic [BTN_IW-1:0]    btn_idx;
    logic                 can_take;
    logic                 wr_ok;
    logic [31:0]          sel_base;
    logic [7:0]           cur_pos;
    logic [7:0]           band_v;
    logic [8:0]           up_sum;
    logic                 inc_hit;
    logic [3:0]           inc_val;
    logic                 band_stop;
    logic                 band_found;
    logic [BAND_W-1:0]    band_idx;
    logic                 new_valid;
    t_event               new_ev;

    assign btn_now  = i_buttons[BUTTON_BITS-1:0];
    assign can_take = !r_pend_valid || i_out_ready;
    assign wr_ok    = (32'(i_map_slot) < NUM_SLOTS) && (32'(i_map_word) < WPS);
    assign sel_base = ((32'(i_shift_plane) * NUM_MODES + 32'(i_mode_sel)) * NUM_SUBMODES
                      + 32'(i_submode_sel)) * NUM_AXES;
    assign cur_pos  = r_pos[r_axis];
    assign band_v   = ~cur_pos;
    assign o_stall  = (r_state != ST_IDLE);
    assign o_pos_raddr = r_slot;

    // Lowest changed button.
    always_comb begin
        btn_idx = '0;
        for (int k = BUTTON_BITS - 1; k >= 0; k--) begin
            if (r_diff[k]) begin
                btn_idx = BTN_IW'(k);
            end
        end
    end

    // Incremental decision; the up step arrives on the map read port.
    always_comb begin
        up_sum = {1'b0, r_old} + {1'b0, i_map_rdata};
        if (cur_pos > r_old) begin
            inc_hit = (up_sum < POS_TOP) && ({1'b0, cur_pos} > up_sum);
            inc_val = 4'd1;
        end else begin
            inc_hit = (r_old > r_down) && (cur_pos < r_old - r_down);
            inc_val = 4'd0;
        end
    end

    // One band threshold per cycle.
    always_comb begin
        band_stop  = 1'b0;
        band_found = 1'b0;
        band_idx   = r_i;
        if (i_map_rdata == 8'd0) begin
            band_stop  = 1'b1;
            band_found = (band_v >= r_prev);
        end else if (band_v >= r_prev && band_v < i_map_rdata) begin
            band_stop  = 1'b1;
            band_found = 1'b1;
        end else if (r_i == BAND_W'(NUM_BANDS - 1)) begin
            band_stop  = 1'b1;
            band_found = (band_v >= i_map_rdata);
            band_idx   = BAND_W'(NUM_BANDS);
        end
    end

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_prev_btn   = r_prev_btn;
        n_diff       = r_diff;
        n_now        = r_now;
        n_pos        = r_pos;
        n_sel_ok     = r_sel_ok;
        n_slot       = r_slot;
        n_map_addr   = r_map_addr;
        n_axis       = r_axis;
        n_incr       = r_incr;
        n_old        = r_old;
        n_down       = r_down;
        n_prev       = r_prev;
        n_i          = r_i;
        n_hit        = r_hit;
        n_val        = r_val;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        o_map_we     = 1'b0;
        o_map_waddr  = r_clr;
        o_map_wdata  = 8'd0;
        o_map_re     = 1'b0;
        o_map_raddr  = r_map_addr;
        o_pos_we     = 1'b0;
        o_pos_waddr  = r_slot;
        o_pos_wdata  = 8'd0;
        o_pos_re     = 1'b0;
        o_push       = 1'b0;
        o_ev         = r_pend;
        new_valid    = 1'b0;
        new_ev       = '{kind: KIND_AXIS, index: 6'd0, value: 4'd0, last: 1'b0};

        unique case (r_state)
            ST_CLEAR: begin
                o_map_we = 1'b1;
                if (32'(r_clr) < NUM_SLOTS) begin
                    o_pos_we    = 1'b1;
                    o_pos_waddr = r_clr[SLOT_W-1:0];
                end
                if (r_clr == MAP_AW'(MAP_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr = r_clr + MAP_AW'(1);
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_command == CMD_MAP_WRITE) begin
                        if (wr_ok) begin
                            o_map_we    = 1'b1;
                            o_map_waddr = MAP_AW'(32'(i_map_slot) * WPS + 32'(i_map_word));
                            o_map_wdata = i_map_value;
                        end
                    end else begin
                        n_prev_btn = btn_now;
                        n_diff     = btn_now ^ r_prev_btn;
                        n_now      = btn_now;
                        n_pos[0]   = i_axis_x;
                        n_pos[1]   = i_axis_y;
                        n_pos[2]   = recenter(i_rotary_a);
                        n_pos[3]   = recenter(i_rotary_b);
                        n_sel_ok   = (32'(i_shift_plane) < NUM_PLANES)
                                  && (32'(i_mode_sel) < NUM_MODES)
                                  && (32'(i_submode_sel) < NUM_SUBMODES);
                        n_slot     = SLOT_W'(sel_base);
                        n_map_addr = MAP_AW'(sel_base * WPS);
                        n_axis     = 2'd0;
                        n_state    = ST_BTN;
                    end
                end
            end
            ST_BTN: begin
                if (r_diff == '0) begin
                    n_state = r_sel_ok ? ST_FLAG : ST_DONE;
                end else if (can_take) begin
                    new_valid       = 1'b1;
                    new_ev.kind     = r_now[btn_idx] ? KIND_PRESS : KIND_RELEASE;
                    new_ev.index    = 6'(btn_idx);
                    n_diff[btn_idx] = 1'b0;
                end
            end
            ST_FLAG: begin
                o_map_re    = 1'b1;
                o_map_raddr = r_map_addr + MAP_AW'(WORD_INCR);
                o_pos_re    = 1'b1;
                n_state     = ST_DOWN;
            end
            ST_DOWN: begin
                n_incr      = (i_map_rdata != 8'd0);
                n_old       = i_pos_rdata;
                o_map_re    = 1'b1;
                o_map_raddr = r_map_addr + MAP_AW'(WORD_DOWN);
                n_state     = ST_UP;
            end
            ST_UP: begin
                n_down   = i_map_rdata;
                o_map_re = 1'b1;
                if (r_incr) begin
                    o_map_raddr = r_map_addr + MAP_AW'(WORD_UP);
                    n_state     = ST_INC;
                end else begin
                    o_map_raddr = r_map_addr + MAP_AW'(WORD_BAND0);
                    n_i         = '0;
                    n_prev      = 8'd0;
                    n_state     = ST_BAND;
                end
            end
            ST_INC: begin
                n_hit = inc_hit;
                n_val = inc_val;
                if (inc_hit) begin
                    o_pos_we    = 1'b1;
                    o_pos_wdata = cur_pos;
                end
                n_state = ST_EMIT;
            end
            ST_BAND: begin
                if (band_stop) begin
                    n_hit = band_found && (8'(band_idx) != r_old);
                    n_val = 4'(band_idx);
                    if (band_found && (8'(band_idx) != r_old)) begin
                        o_pos_we    = 1'b1;
                        o_pos_wdata = 8'(band_idx);
                    end
                    n_state = ST_EMIT;
                end else begin
                    n_prev      = i_map_rdata;
                    n_i         = r_i + BAND_W'(1);
                    o_map_re    = 1'b1;
                    o_map_raddr = r_map_addr + MAP_AW'(WORD_BAND0) + MAP_AW'(r_i)
                                + MAP_AW'(1);
                end
            end
            ST_EMIT: begin
                if (!r_hit || can_take) begin
                    if (r_hit) begin
                        new_valid    = 1'b1;
                        new_ev.index = 6'(r_axis);
                        new_ev.value = r_val;
                    end
                    if (r_axis == 2'(NAX - 1)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_axis     = r_axis + 2'd1;
                        n_slot     = r_slot + SLOT_W'(1);
                        n_map_addr = r_map_addr + MAP_AW'(WPS);
                        n_state    = ST_FLAG;
                    end
                end
            end
            ST_DONE: begin
                if (!r_pend_valid) begin
                    n_state = ST_IDLE;
                end else if (i_out_ready) begin
                    o_push       = 1'b1;
                    o_ev.last    = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase

        // The newest event waits in the pending register until the next
        // one shows that it is not the final word of the report.
        if (new_valid) begin
            o_push       = r_pend_valid;
            o_ev         = r_pend;
            n_pend       = new_ev;
            n_pend_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr        <= '0;
            r_prev_btn   <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_prev_btn   <= n_prev_btn;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_diff     <= n_diff;
        r_now      <= n_now;
        r_pos      <= n_pos;
        r_sel_ok   <= n_sel_ok;
        r_slot     <= n_slot;
        r_map_addr <= n_map_addr;
        r_axis     <= n_axis;
        r_incr     <= n_incr;
        r_old      <= n_old;
        r_down     <= n_down;
        r_prev     <= n_prev;
        r_i        <= n_i;
        r_hit      <= n_hit;
        r_val      <= n_val;
        r_pend     <= n_pend;
    end

endmodule

// ===== hw/rtl/joystick_report_event_mapper.sv =====
// Top level of the joystick report event mapper.
// Depends on jrem_pkg, jrem_ram, jrem_engine and jrem_out_stage.
//
// Input channel (i_valid / o_stall): one word is either a report
// (i_command low) or a single map table byte write (i_command high).
// Output channel (o_valid / i_stall): one word per event. Button events
// come first in ascending button order, then one axis event for each of
// axes 0 to 3 whose translated position changed; o_last marks the final
// event of a report, and a report without changes produces no word.
// A table write produces nothing. In a report the button scan comes
// first, one event per changed button; then each translated axis reads
// its map bytes serially, one byte per cycle (mode flag, down step, then
// the up step in incremental mode or 1..NUM_BANDS band thresholds in
// band mode), and a final step releases the last event.
// Each event waits in a pending register and moves into the output
// register at the edge where the next event is found, so that the final
// one can be marked; the last moves when the report's scan completes.
// After reset the block runs a clearing pass over the map table and the
// position memory with o_stall high. A stalled output holds its word
// and the sequencer pauses when both its pending event and the output
// register are full.
module joystick_report_event_mapper #(
    parameter int NUM_PLANES       = 2,
    parameter int NUM_MODES        = 3,
    parameter int NUM_SUBMODES     = 3,
    parameter int NUM_AXES         = 4,
    parameter int NUM_BANDS        = 15,
    parameter int NUM_BUTTON_BYTES = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_command,
    input  logic [39:0]       i_buttons,
    input  logic [7:0]        i_axis_x,
    input  logic [7:0]        i_axis_y,
    input  logic signed [7:0] i_rotary_a,
    input  logic signed [7:0] i_rotary_b,
    input  logic              i_shift_plane,
    input  logic [1:0]        i_mode_sel,
    input  logic [1:0]        i_submode_sel,
    input  logic [6:0]        i_map_slot,
    input  logic [4:0]        i_map_word,
    input  logic [7:0]        i_map_value,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_event_kind,
    output logic [5:0]        o_event_index,
    output logic [3:0]        o_axis_value,
    output logic              o_last
);
    import jrem_pkg::*;

    // Memory geometry follows from the slot and band counts.
    localparam int NUM_SLOTS = NUM_PLANES * NUM_MODES * NUM_SUBMODES * NUM_AXES;
    localparam int MAP_DEPTH = NUM_SLOTS * (NUM_BANDS + 3);
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);

    logic              map_we;
    logic [MAP_AW-1:0] map_waddr;
    logic [7:0]        map_wdata;
    logic              map_re;
    logic [MAP_AW-1:0] map_raddr;
    logic [7:0]        map_rdata;
    logic              pos_we;
    logic [SLOT_W-1:0] pos_waddr;
    logic [7:0]        pos_wdata;
    logic              pos_re;
    logic [SLOT_W-1:0] pos_raddr;
    logic [7:0]        pos_rdata;
    logic              ev_push;
    t_event            ev_data;
    logic              out_ready;
    t_event            out_ev;

    // Map table: NUM_BANDS + 3 bytes per slot (mode flag, down step,
    // up step, band thresholds).
    jrem_ram #(
        .DEPTH (MAP_DEPTH),
        .WIDTH (8),
        .AW    (MAP_AW)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_re    (map_re),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    // Remembered position per slot: raw position or band index.
    jrem_ram #(
        .DEPTH (NUM_SLOTS),
        .WIDTH (8),
        .AW    (SLOT_W)
    ) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (pos_waddr),
        .i_wdata (pos_wdata),
        .i_re    (pos_re),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata)
    );

    // The sequencer reads, decides and writes back one slot at a time, so
    // a position write always lands before the next read of that slot.
    jrem_engine #(
        .NUM_PLANES       (NUM_PLANES),
        .NUM_MODES        (NUM_MODES),
        .NUM_SUBMODES     (NUM_SUBMODES),
        .NUM_AXES         (NUM_AXES),
        .NUM_BANDS        (NUM_BANDS),
        .NUM_BUTTON_BYTES (NUM_BUTTON_BYTES),
        .SLOT_W           (SLOT_W),
        .MAP_AW           (MAP_AW)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_buttons     (i_buttons),
        .i_axis_x      (i_axis_x),
        .i_axis_y      (i_axis_y),
        .i_rotary_a    (i_rotary_a),
        .i_rotary_b    (i_rotary_b),
        .i_shift_plane (i_shift_plane),
        .i_mode_sel    (i_mode_sel),
        .i_submode_sel (i_submode_sel),
        .i_map_slot    (i_map_slot),
        .i_map_word    (i_map_word),
        .i_map_value   (i_map_value),
        .o_map_we      (map_we),
        .o_map_waddr   (map_waddr),
        .o_map_wdata   (map_wdata),
        .o_map_re      (map_re),
        .o_map_raddr   (map_raddr),
        .i_map_rdata   (map_rdata),
        .o_pos_we      (pos_we),
        .o_pos_waddr   (pos_waddr),
        .o_pos_wdata   (pos_wdata),
        .o_pos_re      (pos_re),
        .o_pos_raddr   (pos_raddr),
        .i_pos_rdata   (pos_rdata),
        .o_push        (ev_push),
        .o_ev          (ev_data),
        .i_out_ready   (out_ready)
    );

    // Output register that decouples the receiver's stall from the scan.
    jrem_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (ev_push),
        .i_ev    (ev_data),
        .o_ready (out_ready),
        .o_valid (o_valid),
        .o_ev    (out_ev),
        .i_stall (i_stall)
    );

    assign o_event_kind  = out_ev.kind;
    assign o_event_index = out_ev.index;
    assign o_axis_value  = out_ev.value;
    assign o_last        = out_ev.last;

endmodule
